[hw/rtl/rci_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_pkg
// shared types, constants, saturating helpers and the back-end program
// ----------------------------------------------------------------------------
package rci_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QDEPTH        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int RF_AW         = 6;
    localparam int PROG_LEN      = 88;
    localparam int PC_W          = 7;

    localparam logic signed [63:0] SATV = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic        [62:0] SATU = 63'h3FFF_FFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd4;

    // load sources
    localparam logic [RF_AW-1:0] SRC_ZERO = 6'd0;
    localparam logic [RF_AW-1:0] SRC_OX   = 6'd1;
    localparam logic [RF_AW-1:0] SRC_OY   = 6'd2;
    localparam logic [RF_AW-1:0] SRC_OZ   = 6'd3;
    localparam logic [RF_AW-1:0] SRC_DX   = 6'd4;
    localparam logic [RF_AW-1:0] SRC_DY   = 6'd5;
    localparam logic [RF_AW-1:0] SRC_DZ   = 6'd6;
    localparam logic [RF_AW-1:0] SRC_CX   = 6'd7;
    localparam logic [RF_AW-1:0] SRC_CY   = 6'd8;
    localparam logic [RF_AW-1:0] SRC_CZ   = 6'd9;
    localparam logic [RF_AW-1:0] SRC_OFF  = 6'd10;
    localparam logic [RF_AW-1:0] SRC_RAD  = 6'd11;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } rci_ray_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [30:0] capsule_height;
        logic        [30:0] capsule_radius;
    } rci_cfg_t;

    typedef struct packed {
        logic     valid;
        rci_ray_t ray;
    } rci_head_t;

    typedef enum logic [3:0] {
        OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQRT, OP_SELP,
        OP_CLAMP, OP_PARF, OP_NZ, OP_LE, OP_GEZ, OP_DONE
    } rci_op_t;

    typedef struct packed {
        rci_op_t          op;
        logic [RF_AW-1:0] dst;
        logic [RF_AW-1:0] sa;
        logic [RF_AW-1:0] sb;
    } rci_inst_t;

    function automatic logic signed [63:0] sat65(input logic signed [64:0] s);
        logic signed [64:0] hi;
        hi = $signed({1'b0, SATV});
        if (s > hi)
            return SATV;
        else if (s < -hi)
            return -SATV;
        else
            return s[63:0];
    endfunction

    function automatic logic signed [63:0] addw(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
        return sat65($signed({a[63], a}) + $signed({b[63], b}));
    endfunction

    function automatic logic signed [63:0] subw(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
        return sat65($signed({a[63], a}) - $signed({b[63], b}));
    endfunction

    // operands always lie within +-SATV
    function automatic logic [62:0] magw(input logic signed [63:0] v);
        logic signed [63:0] n;
        n = -v;
        return v[63] ? n[62:0] : v[62:0];
    endfunction

    function automatic logic signed [63:0] signw(input logic [62:0] m, input logic neg);
        logic signed [63:0] p;
        p = $signed({1'b0, m});
        return neg ? -p : p;
    endfunction

    // register file map: 0 zero, 1-6 ray, 7-9 center, 10 off, 11 radius,
    // 14 pa_y, 15 axis_y, 16-18 w, 19 a, 20 b, 21 c, 22 d, 23 scratch,
    // 24 e, 25 den, 26 tc, 27 tr, 28 tr divisor, 29 cp_y, 30-32 gap,
    // 33-35 oc, 36 r2, 37 gap.gap, 38 l, 39 oc.oc, 40 delta, 41 root/dist
    localparam rci_inst_t PROG [PROG_LEN] = '{
        '{OP_LD,    6'd0,  SRC_ZERO, 6'd0},
        '{OP_LD,    6'd1,  SRC_OX,   6'd0},
        '{OP_LD,    6'd2,  SRC_OY,   6'd0},
        '{OP_LD,    6'd3,  SRC_OZ,   6'd0},
        '{OP_LD,    6'd4,  SRC_DX,   6'd0},
        '{OP_LD,    6'd5,  SRC_DY,   6'd0},
        '{OP_LD,    6'd6,  SRC_DZ,   6'd0},
        '{OP_LD,    6'd7,  SRC_CX,   6'd0},
        '{OP_LD,    6'd8,  SRC_CY,   6'd0},
        '{OP_LD,    6'd9,  SRC_CZ,   6'd0},
        '{OP_LD,    6'd10, SRC_OFF,  6'd0},
        '{OP_LD,    6'd11, SRC_RAD,  6'd0},
        '{OP_ADD,   6'd14, 6'd8,  6'd10},
        '{OP_SUB,   6'd15, 6'd8,  6'd10},
        '{OP_SUB,   6'd15, 6'd15, 6'd14},
        '{OP_SUB,   6'd16, 6'd7,  6'd1},
        '{OP_SUB,   6'd17, 6'd14, 6'd2},
        '{OP_SUB,   6'd18, 6'd9,  6'd3},
        '{OP_MUL,   6'd19, 6'd15, 6'd15},
        '{OP_MUL,   6'd20, 6'd15, 6'd5},
        '{OP_MUL,   6'd21, 6'd15, 6'd17},
        '{OP_MUL,   6'd22, 6'd4,  6'd4},
        '{OP_MUL,   6'd23, 6'd5,  6'd5},
        '{OP_ADD,   6'd22, 6'd22, 6'd23},
        '{OP_MUL,   6'd23, 6'd6,  6'd6},
        '{OP_ADD,   6'd22, 6'd22, 6'd23},
        '{OP_NZ,    6'd0,  6'd22, 6'd0},
        '{OP_MUL,   6'd24, 6'd4,  6'd16},
        '{OP_MUL,   6'd23, 6'd5,  6'd17},
        '{OP_ADD,   6'd24, 6'd24, 6'd23},
        '{OP_MUL,   6'd23, 6'd6,  6'd18},
        '{OP_ADD,   6'd24, 6'd24, 6'd23},
        '{OP_MUL,   6'd25, 6'd19, 6'd22},
        '{OP_MUL,   6'd23, 6'd20, 6'd20},
        '{OP_SUB,   6'd25, 6'd25, 6'd23},
        '{OP_PARF,  6'd0,  6'd25, 6'd0},
        '{OP_MUL,   6'd26, 6'd20, 6'd24},
        '{OP_MUL,   6'd23, 6'd21, 6'd22},
        '{OP_SUB,   6'd26, 6'd26, 6'd23},
        '{OP_MUL,   6'd27, 6'd19, 6'd24},
        '{OP_MUL,   6'd23, 6'd20, 6'd21},
        '{OP_SUB,   6'd27, 6'd27, 6'd23},
        '{OP_SUB,   6'd23, 6'd0,  6'd24},
        '{OP_SELP,  6'd27, 6'd23, 6'd27},
        '{OP_SELP,  6'd28, 6'd22, 6'd25},
        '{OP_DIV,   6'd26, 6'd26, 6'd25},
        '{OP_SELP,  6'd26, 6'd0,  6'd26},
        '{OP_DIV,   6'd27, 6'd27, 6'd28},
        '{OP_CLAMP, 6'd26, 6'd26, 6'd0},
        '{OP_MUL,   6'd29, 6'd26, 6'd15},
        '{OP_ADD,   6'd29, 6'd14, 6'd29},
        '{OP_MUL,   6'd30, 6'd27, 6'd4},
        '{OP_ADD,   6'd30, 6'd1,  6'd30},
        '{OP_SUB,   6'd30, 6'd30, 6'd7},
        '{OP_MUL,   6'd31, 6'd27, 6'd5},
        '{OP_ADD,   6'd31, 6'd2,  6'd31},
        '{OP_SUB,   6'd31, 6'd31, 6'd29},
        '{OP_MUL,   6'd32, 6'd27, 6'd6},
        '{OP_ADD,   6'd32, 6'd3,  6'd32},
        '{OP_SUB,   6'd32, 6'd32, 6'd9},
        '{OP_SUB,   6'd33, 6'd1,  6'd7},
        '{OP_SUB,   6'd34, 6'd2,  6'd29},
        '{OP_SUB,   6'd35, 6'd3,  6'd9},
        '{OP_MUL,   6'd36, 6'd11, 6'd11},
        '{OP_MUL,   6'd37, 6'd30, 6'd30},
        '{OP_MUL,   6'd23, 6'd31, 6'd31},
        '{OP_ADD,   6'd37, 6'd37, 6'd23},
        '{OP_MUL,   6'd23, 6'd32, 6'd32},
        '{OP_ADD,   6'd37, 6'd37, 6'd23},
        '{OP_LE,    6'd0,  6'd37, 6'd36},
        '{OP_MUL,   6'd38, 6'd4,  6'd33},
        '{OP_MUL,   6'd23, 6'd5,  6'd34},
        '{OP_ADD,   6'd38, 6'd38, 6'd23},
        '{OP_MUL,   6'd23, 6'd6,  6'd35},
        '{OP_ADD,   6'd38, 6'd38, 6'd23},
        '{OP_MUL,   6'd39, 6'd33, 6'd33},
        '{OP_MUL,   6'd23, 6'd34, 6'd34},
        '{OP_ADD,   6'd39, 6'd39, 6'd23},
        '{OP_MUL,   6'd23, 6'd35, 6'd35},
        '{OP_ADD,   6'd39, 6'd39, 6'd23},
        '{OP_MUL,   6'd40, 6'd38, 6'd38},
        '{OP_SUB,   6'd40, 6'd40, 6'd39},
        '{OP_ADD,   6'd40, 6'd40, 6'd36},
        '{OP_GEZ,   6'd0,  6'd40, 6'd0},
        '{OP_SQRT,  6'd41, 6'd40, 6'd0},
        '{OP_SUB,   6'd23, 6'd0,  6'd38},
        '{OP_SUB,   6'd41, 6'd23, 6'd41},
        '{OP_DONE,  6'd0,  6'd41, 6'd0}
    };

endpackage

[hw/rtl/rci_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_front
// configuration registers and the ray queue feeding the back end
// ----------------------------------------------------------------------------
module rci_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rci_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  rci_pkg::rci_ray_t                ray,
    output rci_pkg::rci_cfg_t                cfg,
    output rci_pkg::rci_head_t               head,
    input  logic                             pop
);

    localparam int PW = $clog2(rci_pkg::QDEPTH);

    rci_pkg::rci_cfg_t  cfg_reg;
    rci_pkg::rci_ray_t  q_reg [rci_pkg::QDEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [PW:0]        count_reg;
    logic               push;

    assign busy = (count_reg == (PW+1)'(rci_pkg::QDEPTH));
    assign push = start && !busy;
    assign cfg  = cfg_reg;
    assign head = '{valid: (count_reg != '0), ray: q_reg[rd_ptr_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x       <= '0;
            cfg_reg.center_y       <= '0;
            cfg_reg.center_z       <= '0;
            cfg_reg.capsule_height <= 31'd131072;
            cfg_reg.capsule_radius <= 31'd32768;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rci_pkg::CFG_CENTER_X: cfg_reg.center_x       <= cfg_data;
                rci_pkg::CFG_CENTER_Y: cfg_reg.center_y       <= cfg_data;
                rci_pkg::CFG_CENTER_Z: cfg_reg.center_z       <= cfg_data;
                rci_pkg::CFG_HEIGHT:   cfg_reg.capsule_height <= cfg_data[30:0];
                rci_pkg::CFG_RADIUS:   cfg_reg.capsule_radius <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= ray;
    end

endmodule

[hw/rtl/rci_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_back
// program sequencer with a register file, shared multiplier, divider and root
// ----------------------------------------------------------------------------
module rci_back #(
    parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rci_pkg::rci_cfg_t   cfg,
    input  rci_pkg::rci_head_t  head,
    output logic                pop,
    output logic                done,
    output logic                hit,
    output logic [30:0]         hit_distance
);

    localparam int DIV_STEPS = 64 + FRAC_BITS;
    localparam int NW        = 64 + FRAC_BITS;
    localparam int SQ_STEPS  = 44;
    localparam int SQW       = 2 * SQ_STEPS;
    localparam int CW        = 7;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic [63:0] EPS = (64'd1 << FRAC_BITS) / 64'd1000000;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_EXEC = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_SQRT = 7'b0100000,
        S_WB   = 7'b1000000
    } rci_state_t;

    rci_state_t state_reg;
    logic [rci_pkg::PC_W-1:0] pc_reg;
    rci_pkg::rci_inst_t inst;

    logic signed [63:0] mem [2**rci_pkg::RF_AW];
    logic signed [63:0] a_reg, b_reg;

    logic par_reg, dnz_reg, gok_reg, dok_reg;
    logic done_reg, hit_reg;
    logic [30:0] dist_reg;

    logic [CW-1:0] cnt_reg;

    // multiplier
    logic [62:0]  ma_reg, mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [31:0]  mul_ah, mul_bh;
    logic [63:0]  pp;
    logic [127:0] addend;
    logic [127:0] shifted;
    logic [62:0]  mul_mag;
    logic signed [63:0] mul_res;

    // divider
    logic [NW-1:0] num_reg;
    logic [62:0]   md_reg;
    logic [63:0]   rem_reg, q_reg;
    logic          dsat_reg;
    logic [63:0]   rem_s, rem_n, q_n;
    logic          dsat_n;
    logic signed [63:0] div_res;

    // square root
    logic [SQW-1:0] x_reg;
    logic [47:0]    srem_reg;
    logic [43:0]    root_reg;
    logic [47:0]    srem_s, trial;

    logic               wr_en;
    logic [rci_pkg::RF_AW-1:0] wr_addr;
    logic signed [63:0] wr_data;
    logic signed [63:0] ld_val, alu_val, wb_val;

    assign inst = rci_pkg::PROG[pc_reg];
    assign pop  = (state_reg == S_EXEC) && (inst.op == rci_pkg::OP_DONE);
    assign done = done_reg;
    assign hit  = hit_reg;
    assign hit_distance = dist_reg;

    // load sources
    always_comb
    begin
        case (inst.sa)
            rci_pkg::SRC_OX:  ld_val = 64'(head.ray.origin_x);
            rci_pkg::SRC_OY:  ld_val = 64'(head.ray.origin_y);
            rci_pkg::SRC_OZ:  ld_val = 64'(head.ray.origin_z);
            rci_pkg::SRC_DX:  ld_val = 64'(head.ray.dir_x);
            rci_pkg::SRC_DY:  ld_val = 64'(head.ray.dir_y);
            rci_pkg::SRC_DZ:  ld_val = 64'(head.ray.dir_z);
            rci_pkg::SRC_CX:  ld_val = 64'(cfg.center_x);
            rci_pkg::SRC_CY:  ld_val = 64'(cfg.center_y);
            rci_pkg::SRC_CZ:  ld_val = 64'(cfg.center_z);
            rci_pkg::SRC_OFF: ld_val = $signed({34'b0, cfg.capsule_height[30:1]})
                                       - $signed({33'b0, cfg.capsule_radius});
            rci_pkg::SRC_RAD: ld_val = $signed({33'b0, cfg.capsule_radius});
            default:          ld_val = '0;
        endcase
    end

    always_comb
    begin
        case (inst.op)
            rci_pkg::OP_LD:   alu_val = ld_val;
            rci_pkg::OP_ADD:  alu_val = rci_pkg::addw(a_reg, b_reg);
            rci_pkg::OP_SUB:  alu_val = rci_pkg::subw(a_reg, b_reg);
            rci_pkg::OP_SELP: alu_val = par_reg ? a_reg : b_reg;
            rci_pkg::OP_CLAMP:
            begin
                if (a_reg[63])
                    alu_val = '0;
                else if (a_reg > ONE)
                    alu_val = ONE;
                else
                    alu_val = a_reg;
            end
            default:          alu_val = '0;
        endcase
    end

    // partial products: a0*b0, a0*b1, a1*b0, a1*b1
    assign mul_ah  = cnt_reg[1] ? {1'b0, ma_reg[62:32]} : ma_reg[31:0];
    assign mul_bh  = cnt_reg[0] ? {1'b0, mb_reg[62:32]} : mb_reg[31:0];
    assign pp      = 64'(mul_ah) * 64'(mul_bh);
    assign addend  = {64'b0, pp} << {cnt_reg[1] & cnt_reg[0], cnt_reg[1] ^ cnt_reg[0], 5'b0};
    assign shifted = acc_reg >> FRAC_BITS;
    assign mul_mag = (|shifted[127:62]) ? rci_pkg::SATU : shifted[62:0];
    assign mul_res = rci_pkg::signw(mul_mag, neg_reg);

    // one restoring step per cycle, quotient saturates
    always_comb
    begin
        rem_s  = {rem_reg[62:0], num_reg[NW-1]};
        dsat_n = dsat_reg;
        q_n    = q_reg;
        if (q_reg > {2'b0, rci_pkg::SATU[62:1]})
            dsat_n = 1'b1;
        else
            q_n = {q_reg[62:0], 1'b0};
        rem_n = rem_s;
        if (rem_s >= {1'b0, md_reg})
        begin
            rem_n = rem_s - {1'b0, md_reg};
            if (!dsat_n)
                q_n = q_n | 64'd1;
        end
    end

    assign div_res = (md_reg == '0) ? 64'sd0
                   : rci_pkg::signw(dsat_reg ? rci_pkg::SATU : q_reg[62:0], neg_reg);

    assign srem_s = {srem_reg[45:0], x_reg[SQW-1 -: 2]};
    assign trial  = {2'b0, root_reg, 2'b01};

    always_comb
    begin
        case (inst.op)
            rci_pkg::OP_MUL: wb_val = mul_res;
            rci_pkg::OP_DIV: wb_val = div_res;
            default:         wb_val = $signed({20'b0, root_reg});
        endcase
    end

    always_comb
    begin
        wr_addr = inst.dst;
        wr_data = alu_val;
        wr_en   = 1'b0;
        if (state_reg == S_EXEC)
        begin
            case (inst.op)
                rci_pkg::OP_LD, rci_pkg::OP_ADD, rci_pkg::OP_SUB,
                rci_pkg::OP_SELP, rci_pkg::OP_CLAMP: wr_en = 1'b1;
                default: wr_en = 1'b0;
            endcase
        end
        else if (state_reg == S_WB)
        begin
            wr_en   = 1'b1;
            wr_data = wb_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (state_reg == S_READ)
        begin
            a_reg <= mem[inst.sa];
            b_reg <= mem[inst.sb];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
            par_reg   <= 1'b0;
            dnz_reg   <= 1'b0;
            gok_reg   <= 1'b0;
            dok_reg   <= 1'b0;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            dist_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    pc_reg <= '0;
                    if (head.valid)
                        state_reg <= S_READ;
                end
                S_READ: state_reg <= S_EXEC;
                S_EXEC:
                begin
                    cnt_reg <= '0;
                    pc_reg  <= pc_reg + 1'b1;
                    state_reg <= S_READ;
                    case (inst.op)
                        rci_pkg::OP_MUL:
                        begin
                            pc_reg    <= pc_reg;
                            state_reg <= S_MUL;
                        end
                        rci_pkg::OP_DIV:
                        begin
                            pc_reg    <= pc_reg;
                            state_reg <= S_DIV;
                        end
                        rci_pkg::OP_SQRT:
                        begin
                            pc_reg    <= pc_reg;
                            state_reg <= S_SQRT;
                        end
                        rci_pkg::OP_PARF: par_reg <= ({1'b0, rci_pkg::magw(a_reg)} <= EPS);
                        rci_pkg::OP_NZ:   dnz_reg <= (a_reg != '0);
                        rci_pkg::OP_LE:   gok_reg <= (a_reg <= b_reg);
                        rci_pkg::OP_GEZ:  dok_reg <= !a_reg[63];
                        rci_pkg::OP_DONE:
                        begin
                            done_reg  <= 1'b1;
                            hit_reg   <= dnz_reg && gok_reg && dok_reg && !a_reg[63];
                            if (!(dnz_reg && gok_reg && dok_reg) || a_reg[63])
                                dist_reg <= '0;
                            else if (|a_reg[62:31])
                                dist_reg <= '1;
                            else
                                dist_reg <= a_reg[30:0];
                            state_reg <= S_IDLE;
                        end
                        default: ;
                    endcase
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(3))
                        state_reg <= S_WB;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(DIV_STEPS - 1))
                        state_reg <= S_WB;
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(SQ_STEPS - 1))
                        state_reg <= S_WB;
                end
                S_WB:
                begin
                    pc_reg    <= pc_reg + 1'b1;
                    state_reg <= S_READ;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // arithmetic unit datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            ma_reg   <= rci_pkg::magw(a_reg);
            mb_reg   <= rci_pkg::magw(b_reg);
            neg_reg  <= a_reg[63] ^ b_reg[63];
            acc_reg  <= '0;
            num_reg  <= NW'(rci_pkg::magw(a_reg)) << FRAC_BITS;
            md_reg   <= rci_pkg::magw(b_reg);
            rem_reg  <= '0;
            q_reg    <= '0;
            dsat_reg <= 1'b0;
            x_reg    <= (a_reg > 64'sd0) ? (SQW'(a_reg[62:0]) << FRAC_BITS) : '0;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (state_reg == S_MUL)
            acc_reg <= acc_reg + addend;
        else if (state_reg == S_DIV)
        begin
            rem_reg  <= rem_n;
            q_reg    <= q_n;
            dsat_reg <= dsat_n;
            num_reg  <= {num_reg[NW-2:0], 1'b0};
        end
        else if (state_reg == S_SQRT)
        begin
            x_reg <= {x_reg[SQW-3:0], 2'b00};
            if (srem_s >= trial)
            begin
                srem_reg <= srem_s - trial;
                root_reg <= {root_reg[42:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_s;
                root_reg <= {root_reg[42:0], 1'b0};
            end
        end
    end

endmodule

[hw/rtl/ray_capsule_intersection_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_capsule_intersection_unit
// ray versus vertical capsule test in signed fixed point with saturation
// ----------------------------------------------------------------------------
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+------------------
//  config    | cfg_we, cfg_index, cfg_data               | write on cfg_we
//  ray in    | start, busy, origin_*, dir_*              | start && !busy
//  result    | done, hit, hit_distance                   | done, one cycle
//
//  a ray runs through the shared 32x32 multiplier (30 products, each summed from
//  four partial products), the bit-serial divider (two quotients) and the
//  44-step root, all on one register file
//  a two-word queue takes new rays while the back end works; busy means full
//  reset clears the queue, the sequencer and the capsule center, and sets
//  height and radius to defaults; the result strobe cannot be held off
// ----------------------------------------------------------------------------
module ray_capsule_intersection_unit #(
    parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rci_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [31:0]             origin_x,
    input  logic signed [31:0]             origin_y,
    input  logic signed [31:0]             origin_z,
    input  logic signed [31:0]             dir_x,
    input  logic signed [31:0]             dir_y,
    input  logic signed [31:0]             dir_z,
    output logic                           done,
    output logic                           hit,
    output logic [30:0]                    hit_distance
);

    rci_pkg::rci_ray_t  ray;
    rci_pkg::rci_cfg_t  cfg;
    rci_pkg::rci_head_t head;
    logic               pop;

    assign ray = '{origin_x: origin_x, origin_y: origin_y, origin_z: origin_z,
                   dir_x: dir_x, dir_y: dir_y, dir_z: dir_z};

    rci_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .ray       (ray),
        .cfg       (cfg),
        .head      (head),
        .pop       (pop)
    );

    rci_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .pop          (pop),
        .done         (done),
        .hit          (hit),
        .hit_distance (hit_distance)
    );

endmodule
